// ===== hw/rtl/stwg_pkg.sv =====
// shared types and constants for the spiral tile wipe generator
package stwg_pkg;

    localparam int FRAME_BITS          = 12;
    localparam int STEP_BITS           = 9;
    localparam int TILE_SHIFT          = 3;
    localparam int COORD_WIDTH_DEFAULT = 12;
    localparam int CFG_INDEX_BITS      = 2;

    localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = 12'd480;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        HEAD_RIGHT = 2'd0,
        HEAD_DOWN  = 2'd1,
        HEAD_LEFT  = 2'd2,
        HEAD_UP    = 2'd3
    } heading_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] tile_x;
        logic [FRAME_BITS-1:0] tile_y;
        logic [STEP_BITS-1:0]  tile_width;
        logic [STEP_BITS-1:0]  tile_height;
        logic                  finished;
    } result_t;

endpackage

// ===== hw/rtl/stwg_core.sv =====
// spiral walk state and single-tick step logic
module stwg_core #(
    parameter int COORD_WIDTH = stwg_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step_en,
    input  logic                             restart,
    input  logic [stwg_pkg::FRAME_BITS-1:0]  frame_width,
    input  logic [stwg_pkg::FRAME_BITS-1:0]  frame_height,
    output stwg_pkg::result_t                result
);
    import stwg_pkg::*;

    localparam int EXT_BITS = COORD_WIDTH + FRAME_BITS;

    function automatic logic [COORD_WIDTH-1:0] coord_of_frame(logic [FRAME_BITS-1:0] v);
        logic [EXT_BITS-1:0] e;
        e = EXT_BITS'(v);
        return e[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [COORD_WIDTH-1:0] coord_of_step(logic [STEP_BITS-1:0] v);
        logic [EXT_BITS-1:0] e;
        e = EXT_BITS'(v);
        return e[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [FRAME_BITS-1:0] frame_of_coord(logic [COORD_WIDTH-1:0] v);
        logic [EXT_BITS-1:0] e;
        e = EXT_BITS'(v);
        return e[FRAME_BITS-1:0];
    endfunction

    logic [COORD_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic [COORD_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic [COORD_WIDTH-1:0] left_reg, left_next;
    logic [COORD_WIDTH-1:0] right_reg, right_next;
    logic [COORD_WIDTH-1:0] top_reg, top_next;
    logic [COORD_WIDTH-1:0] bottom_reg, bottom_next;
    heading_t               heading_reg, heading_next;
    logic [STEP_BITS-1:0]   step_w_reg, step_w_next;
    logic [STEP_BITS-1:0]   step_h_reg, step_h_next;

    logic [COORD_WIDTH-1:0] ld_px, ld_py, ld_left, ld_right, ld_top, ld_bottom;
    heading_t               ld_heading;
    logic [STEP_BITS-1:0]   ld_sw, ld_sh;
    logic [COORD_WIDTH-1:0] sw_c, sh_c;
    logic                   done;

    always_comb
    begin
        // restart reload
        if (restart)
        begin
            ld_sw      = frame_width[FRAME_BITS-1:TILE_SHIFT];
            ld_sh      = frame_height[FRAME_BITS-1:TILE_SHIFT];
            ld_left    = '0;
            ld_right   = coord_of_frame(frame_width - FRAME_BITS'(ld_sw));
            ld_top     = coord_of_step(ld_sh);
            ld_bottom  = coord_of_frame(frame_height - FRAME_BITS'(ld_sh));
            ld_heading = HEAD_RIGHT;
            ld_px      = '0;
            ld_py      = '0;
        end
        else
        begin
            ld_sw      = step_w_reg;
            ld_sh      = step_h_reg;
            ld_left    = left_reg;
            ld_right   = right_reg;
            ld_top     = top_reg;
            ld_bottom  = bottom_reg;
            ld_heading = heading_reg;
            ld_px      = pos_x_reg;
            ld_py      = pos_y_reg;
        end

        sw_c = coord_of_step(ld_sw);
        sh_c = coord_of_step(ld_sh);
        done = (ld_heading == HEAD_RIGHT) && (ld_left >= ld_right);

        step_w_next  = ld_sw;
        step_h_next  = ld_sh;
        left_next    = ld_left;
        right_next   = ld_right;
        top_next     = ld_top;
        bottom_next  = ld_bottom;
        heading_next = ld_heading;
        pos_x_next   = ld_px;
        pos_y_next   = ld_py;
        result       = '0;

        if (done)
        begin
            result.finished = 1'b1;
        end
        else
        begin
            // corner turn
            unique case (ld_heading)
                HEAD_RIGHT:
                begin
                    if (ld_px >= ld_right)
                    begin
                        heading_next = HEAD_DOWN;
                        right_next   = ld_right - sw_c;
                    end
                end
                HEAD_DOWN:
                begin
                    if (ld_py >= ld_bottom)
                    begin
                        heading_next = HEAD_LEFT;
                        bottom_next  = ld_bottom - sh_c;
                    end
                end
                HEAD_LEFT:
                begin
                    if (ld_px <= ld_left)
                    begin
                        heading_next = HEAD_UP;
                        left_next    = ld_left + sw_c;
                    end
                end
                HEAD_UP:
                begin
                    if (ld_py <= ld_top)
                    begin
                        heading_next = HEAD_RIGHT;
                        top_next     = ld_top + sh_c;
                    end
                end
            endcase

            result.tile_x      = frame_of_coord(ld_px);
            result.tile_y      = frame_of_coord(ld_py);
            result.tile_width  = ld_sw;
            result.tile_height = ld_sh;

            // advance one tile
            unique case (heading_next)
                HEAD_RIGHT: pos_x_next = ld_px + sw_c;
                HEAD_DOWN:  pos_y_next = ld_py + sh_c;
                HEAD_LEFT:  pos_x_next = ld_px - sw_c;
                HEAD_UP:    pos_y_next = ld_py - sh_c;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            left_reg    <= '0;
            right_reg   <= '0;
            top_reg     <= '0;
            bottom_reg  <= '0;
            heading_reg <= HEAD_RIGHT;
            step_w_reg  <= '0;
            step_h_reg  <= '0;
        end
        else if (step_en)
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            left_reg    <= left_next;
            right_reg   <= right_next;
            top_reg     <= top_next;
            bottom_reg  <= bottom_next;
            heading_reg <= heading_next;
            step_w_reg  <= step_w_next;
            step_h_reg  <= step_h_next;
        end
    end

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !restart && done |=> $stable(heading_reg) && $stable(pos_x_reg)
            && $stable(pos_y_reg) && $stable(right_reg))
        else $error("finished tick changed the walk state");

    a_restart_loads: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && restart |=> step_w_reg == $past(frame_width[FRAME_BITS-1:TILE_SHIFT])
            && step_h_reg == $past(frame_height[FRAME_BITS-1:TILE_SHIFT]))
        else $error("restart did not load the tile size");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(heading_reg) && $stable(pos_x_reg) && $stable(left_reg))
        else $error("walk state moved without a tick");

endmodule

// ===== hw/rtl/spiral_tile_wipe_generator.sv =====
// top level: config registers, tick handshake and output skid buffer
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  tick    | in        | in_valid/in_stall  | restart
//  tile    | out       | out_valid/out_stall| tile_x, tile_y, tile_width, tile_height,
//          |           |                    | finished
//  config  | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one tick per cycle unless in_stall; results are registered in the output buffer
//  the step is a single compare/add pass between the walk state and the output register
//  a two-entry output buffer lets a tick be taken while a result waits; in_stall is
//  driven from the second entry only
//  reset gives 640 x 480 and a finished walk until the first restart
module spiral_tile_wipe_generator #(
    parameter int COORD_WIDTH = stwg_pkg::COORD_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [stwg_pkg::FRAME_BITS-1:0]     tile_x,
    output logic [stwg_pkg::FRAME_BITS-1:0]     tile_y,
    output logic [stwg_pkg::STEP_BITS-1:0]      tile_width,
    output logic [stwg_pkg::STEP_BITS-1:0]      tile_height,
    output logic                                finished,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stwg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [stwg_pkg::FRAME_BITS-1:0]     cfg_data
);
    import stwg_pkg::*;

    logic [FRAME_BITS-1:0] frame_width_reg;
    logic [FRAME_BITS-1:0] frame_height_reg;
    result_t               step_result;
    result_t               out_reg;
    result_t               skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  accept;
    logic                  out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    stwg_core #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (accept),
        .restart      (restart),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .result       (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : step_result;
        end
        else if (accept)
        begin
            skid_reg <= step_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tile_x      = out_reg.tile_x;
    assign tile_y      = out_reg.tile_y;
    assign tile_width  = out_reg.tile_width;
    assign tile_height = out_reg.tile_height;
    assign finished    = out_reg.finished;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("second entry full with first entry empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall && in_valid))
        else $error("second entry filled without a held result");

    a_finished_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.finished |-> out_reg.tile_x == '0 && out_reg.tile_y == '0
            && out_reg.tile_width == '0 && out_reg.tile_height == '0)
        else $error("finished result carries a tile");

endmodule
